>>> rtl/x86_page_table_walker_defines.svh
// ----------------------------------------------------------------------------
// x86_page_table_walker_defines
// Assertion macros used by the page table walker sequencer.
// ----------------------------------------------------------------------------
`ifndef X86_PAGE_TABLE_WALKER_DEFINES_SVH
`define X86_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants of the x86-64 four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam int AT_W = 37;
  localparam logic [AT_W-1:0] MEM_BYTES = AT_W'(MEM_WORDS) << 3;
  localparam logic [AT_W-1:0] ENTRY_BYTES = AT_W'(8);

  localparam logic [63:0] CR3_ALLOWED = 64'h0000_000f_ffff_f018;
  localparam logic [16:0] VA_TOP_HIGH = 17'h1ffff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam int CFG_W     = 16;
  localparam int CFG_RESET = 32768;

  typedef struct packed {
    logic        op;
    logic [11:0] word_index;
    logic [63:0] word_data;
    logic [63:0] table_root;
    logic [63:0] virtual_address;
    logic        is_write;
    logic        is_execute;
  } ptw_req_t;

  typedef struct packed {
    logic        ok;
    logic [35:0] physical_address;
    logic [2:0]  levels_read;
    logic [14:0] entry_addr_0;
    logic [14:0] entry_addr_1;
    logic [14:0] entry_addr_2;
    logic [14:0] entry_addr_3;
  } ptw_result_t;

  typedef struct packed {
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [63:0]       wr_data;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
  } ptw_ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ADDR,
    ST_CHECK,
    ST_DONE
  } ptw_state_t;

endpackage

>>> rtl/ptw_table_ram.sv
// ----------------------------------------------------------------------------
// ptw_table_ram
// Table word memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptw_table_ram (
  input  logic                  clk,
  input  ptw_pkg::ptw_ram_req_t ram_req,
  output logic [63:0]           rd_data
);
  import ptw_pkg::*;

  logic [63:0] mem [MEM_WORDS];

  always_ff @(posedge clk) begin
    if (ram_req.wr_en) begin
      mem[ram_req.wr_addr] <= ram_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_req.rd_en) begin
      rd_data <= mem[ram_req.rd_addr];
    end
  end

endmodule

>>> rtl/ptw_walker.sv
// ----------------------------------------------------------------------------
// ptw_walker
// Sequencer: stores table words and walks up to four levels, one read per level.
// ----------------------------------------------------------------------------
`include "x86_page_table_walker_defines.svh"

module ptw_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ptw_pkg::CFG_W-1:0]   mem_size,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ptw_pkg::ptw_req_t           req,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ptw_pkg::ptw_result_t        res,
  output ptw_pkg::ptw_ram_req_t       ram_req,
  input  logic [63:0]                 ram_rd_data
);
  import ptw_pkg::*;

  ptw_state_t state, state_next;

  logic [63:0] cr3;
  logic [63:0] va;
  logic        wr;
  logic        ex;
  logic [23:0] table_base;
  logic [1:0]  lvl;
  logic        res_ok;
  logic [35:0] pa;
  logic [2:0]  count;
  logic [14:0] ea [4];

  logic              accept;
  logic [31:0]       idx_wide;
  logic              idx_in_range;
  logic              pre_ok;
  logic [8:0]        va_idx;
  logic [35:0]       at;
  logic [AT_W-1:0]   at_end;
  logic [AT_W-1:0]   limit;
  logic              in_bounds;
  logic [63:0]       e;
  logic              e_large;
  logic              e_fault;
  logic              e_final;

  assign accept       = req_valid && req_ready;
  assign idx_wide     = 32'(req.word_index);
  assign idx_in_range = idx_wide < 32'(MEM_WORDS);

  assign pre_ok = (va[63:47] == '0 || va[63:47] == VA_TOP_HIGH) &&
                  ((cr3 & ~CR3_ALLOWED) == '0);

  always_comb begin
    case (lvl)
      2'd3:    va_idx = va[47:39];
      2'd2:    va_idx = va[38:30];
      2'd1:    va_idx = va[29:21];
      default: va_idx = va[20:12];
    endcase
  end

  assign at        = {table_base, va_idx, 3'b000};
  assign at_end    = AT_W'(at) + ENTRY_BYTES;
  assign limit     = (AT_W'(mem_size) < MEM_BYTES) ? AT_W'(mem_size) : MEM_BYTES;
  assign in_bounds = at_end <= limit;

  assign e       = ram_rd_data;
  assign e_large = e[7] && (lvl != 2'd0);
  assign e_fault = !e[0] || (e[51:36] != '0) || (wr && !e[1]) || (ex && e[63]) ||
                   (e_large && (lvl != 2'd1)) || (e_large && (e[20:13] != '0));
  assign e_final = (lvl == 2'd0) || e_large;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req.op == OP_WRITE) ? ST_DONE : ST_START;
        end
      end
      ST_START: state_next = pre_ok ? ST_ADDR : ST_DONE;
      ST_ADDR:  state_next = in_bounds ? ST_CHECK : ST_DONE;
      ST_CHECK: state_next = (e_fault || e_final) ? ST_DONE : ST_ADDR;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = idx_wide[MEM_AW-1:0];
    ram_req.wr_data = req.word_data;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = at[MEM_AW+2:3];
    case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        ram_req.wr_en = req_valid && (req.op == OP_WRITE) && idx_in_range;
      end
      ST_ADDR: ram_req.rd_en = in_bounds;
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_ok <= (req.op == OP_WRITE) && idx_in_range;
          cr3    <= req.table_root;
          va     <= req.virtual_address;
          wr     <= req.is_write;
          ex     <= req.is_execute;
          pa     <= '0;
          count  <= '0;
          for (int i = 0; i < 4; i++) begin
            ea[i] <= '0;
          end
        end
      end
      ST_START: begin
        table_base <= cr3[35:12];
        lvl        <= 2'd3;
      end
      ST_ADDR: begin
        if (in_bounds) begin
          ea[~lvl] <= at[14:0];
          count    <= count + 3'd1;
        end
      end
      ST_CHECK: begin
        if (!e_fault) begin
          if (lvl == 2'd0) begin
            res_ok <= 1'b1;
            pa     <= {e[35:12], va[11:0]};
          end else if (e_large) begin
            res_ok <= 1'b1;
            pa     <= {e[35:21], va[20:0]};
          end else begin
            table_base <= e[35:12];
            lvl        <= lvl - 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.ok               = res_ok;
    res.physical_address = res_ok ? pa : '0;
    res.levels_read      = res_ok ? count : '0;
    res.entry_addr_0     = res_ok ? ea[0] : '0;
    res.entry_addr_1     = res_ok ? ea[1] : '0;
    res.entry_addr_2     = res_ok ? ea[2] : '0;
    res.entry_addr_3     = res_ok ? ea[3] : '0;
  end

  `PTW_ASSERT_SAME(a_no_rw_overlap, ram_req.wr_en, !ram_req.rd_en, "table read and write in one cycle")
  `PTW_ASSERT_SAME(a_check_after_read, state == ST_CHECK, $past(ram_req.rd_en), "entry check without a table read")
  `PTW_ASSERT_SAME(a_walk_depth, res_valid && res.ok && res.levels_read != 3'd0, res.levels_read == 3'd3 || res.levels_read == 3'd4, "successful walk with bad depth")

endmodule

>>> rtl/x86_page_table_walker.sv
// ----------------------------------------------------------------------------
// x86_page_table_walker
// x86-64 four-level page table walker over a 64-bit table word memory.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel; tuser selects a table word write (0)
// or a translation (1). Every request yields exactly one result on m_axis.
// cfg_wr_en/cfg_wr_data set the readable table memory size in bytes; write it
// only while no request is in flight.
// A write request goes straight from idle to the result. A translation reads
// one table level at a time: address and bounds check, then the entry check
// on the registered read data. A 4 KiB page reads four levels, a 2 MiB page
// three, and a fault ends the walk early. The table memory has a single read
// port, and each level depends on the entry read before it.
// A new request is accepted once the previous result has moved into the
// output register, so a stalled receiver holds one finished result there
// while the next request is walked.
// Reset empties the output register, returns the sequencer to idle and sets
// the memory size to 32768. Table memory contents are not cleared.
// ----------------------------------------------------------------------------
module x86_page_table_walker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ptw_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // word_index[11:0], word_data[75:12], table_root[139:76],
  // virtual_address[203:140], is_write[204], is_execute[205], zero[207:206]
  input  logic [207:0]               s_axis_tdata,
  // op[0]
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // ok[0], physical_address[36:1], levels_read[39:37], entry_addr_0[54:40],
  // entry_addr_1[69:55], entry_addr_2[84:70], entry_addr_3[99:85], zero[103:100]
  output logic [103:0]               m_axis_tdata
);
  import ptw_pkg::*;

  logic [CFG_W-1:0] mem_size;
  ptw_req_t         req;
  ptw_result_t      res;
  logic             res_valid;
  logic             res_ready;
  ptw_ram_req_t     ram_req;
  logic [63:0]      ram_rd_data;
  logic             out_valid;
  ptw_result_t      out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= CFG_W'(CFG_RESET);
    end else if (cfg_wr_en) begin
      mem_size <= cfg_wr_data;
    end
  end

  always_comb begin
    req.op              = s_axis_tuser;
    req.word_index      = s_axis_tdata[11:0];
    req.word_data       = s_axis_tdata[75:12];
    req.table_root      = s_axis_tdata[139:76];
    req.virtual_address = s_axis_tdata[203:140];
    req.is_write        = s_axis_tdata[204];
    req.is_execute      = s_axis_tdata[205];
  end

  ptw_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .mem_size    (mem_size),
    .req_valid   (s_axis_tvalid),
    .req_ready   (s_axis_tready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  ptw_table_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rd_data (ram_rd_data)
  );

  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.entry_addr_3, out_res.entry_addr_2,
                          out_res.entry_addr_1, out_res.entry_addr_0,
                          out_res.levels_read, out_res.physical_address,
                          out_res.ok};

endmodule

>>> verif/x86_page_table_walker_tb.sv
// ----------------------------------------------------------------------------
// x86_page_table_walker_tb
// Self-checking bench for the four-level page table walker. Table words are
// loaded and translations requested over the request stream; a scoreboard
// walks its own copy of the tables to predict every result. Directed cases
// hit each page size and each entry fault, then random walks run across several
// memory sizes with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module x86_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  localparam logic [63:0] ADDR_FIELD   = 64'h0000_000f_ffff_f000;
  localparam logic [63:0] LARGE_LOW_OK = 64'h1fff;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  logic [63:0]  table_words [MEM_WORDS];
  bit           word_written [MEM_WORDS];
  logic [15:0]  readable_bytes = 16'(CFG_RESET);
  ptw_result_t  pending_results [$];
  int unsigned  requests_sent = 0;
  int unsigned  mismatches = 0;
  bit           src_gaps = 1'b1;
  bit           dst_stalls = 1'b1;

  x86_page_table_walker u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("x86_page_table_walker_tb: errors");
    $finish;
  end

  // Walk the scoreboard tables; gap_word is the first unloaded word the walk reads.
  function automatic void walk_table(input ptw_req_t req, output ptw_result_t res,
                                     output int gap_word, output int gap_level);
    logic [63:0] base, at, lim, ent, mask, pa, va;
    logic [14:0] ea [4];
    int lvl, shift, n;
    bit huge;
    res = '0;
    gap_word = -1;
    gap_level = 0;
    va = req.virtual_address;
    ea = '{default: '0};
    if (!(va[63:47] == 17'h0 || va[63:47] == VA_TOP_HIGH) ||
        (req.table_root & ~CR3_ALLOWED) != 0)
      return;
    lim = (64'(readable_bytes) < 64'(MEM_WORDS) * 8) ? 64'(readable_bytes)
                                                     : 64'(MEM_WORDS) * 8;
    base = req.table_root & ADDR_FIELD;
    n = 0;
    for (lvl = 4; lvl >= 1; lvl--) begin
      shift = 12 + 9 * (lvl - 1);
      at = base + ((va >> shift) & 64'd511) * 8;
      if (at > lim || lim - at < 8)
        return;
      if (!word_written[at[14:3]]) begin
        gap_word = int'(at[14:3]);
        gap_level = lvl;
        return;
      end
      ent = table_words[at[14:3]];
      ea[n] = at[14:0];
      n++;
      if (!ent[0] || ent[51:36] != 0 || (req.is_write && !ent[1]) ||
          (req.is_execute && ent[63]))
        return;
      huge = ent[7] && lvl > 1;
      if (huge && lvl != 2)
        return;
      if (lvl == 1 || huge) begin
        mask = (64'd1 << shift) - 1;
        if (huge && (ent & mask & ~LARGE_LOW_OK) != 0)
          return;
        pa = (ent & ADDR_FIELD & ~mask) | (va & mask);
        res.ok = 1'b1;
        res.physical_address = pa[35:0];
        res.levels_read = 3'(n);
        res.entry_addr_0 = ea[0];
        res.entry_addr_1 = ea[1];
        res.entry_addr_2 = ea[2];
        res.entry_addr_3 = ea[3];
        return;
      end
      base = ent & ADDR_FIELD;
    end
  endfunction

  function automatic ptw_result_t request_outcome(input ptw_req_t req);
    ptw_result_t res;
    int gw, gl;
    res = '0;
    if (req.op == OP_WRITE) begin
      if (int'(req.word_index) < MEM_WORDS) begin
        table_words[req.word_index] = req.word_data;
        word_written[req.word_index] = 1'b1;
        res.ok = 1'b1;
      end
    end else begin
      walk_table(req, res, gw, gl);
    end
    return res;
  endfunction

  function automatic logic [63:0] make_entry(input int lvl);
    logic [63:0] e;
    e = {$urandom, $urandom};
    e[51:36] = ($urandom_range(0, 31) == 0) ? 16'($urandom) : 16'h0;
    e[0]  = ($urandom_range(0, 15) != 0);
    e[1]  = ($urandom_range(0, 15) != 0);
    e[63] = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 15) != 0)
      e[35:12] = 24'($urandom_range(0, 7));
    if (lvl == 2)
      e[7] = ($urandom_range(0, 3) == 0);
    else if (lvl > 2)
      e[7] = ($urandom_range(0, 31) == 0);
    if (lvl == 2 && e[7] && $urandom_range(0, 3) != 0) begin
      e[35:21] = 15'($urandom);
      e[20:13] = 8'h0;
    end
    return e;
  endfunction

  function automatic void flag_error(input string what, input ptw_result_t want,
                                     input ptw_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want ok=%0b pa=%h lv=%0d ea=%h %h %h %h",
               $realtime, what, want.ok, want.physical_address, want.levels_read,
               want.entry_addr_0, want.entry_addr_1, want.entry_addr_2,
               want.entry_addr_3);
      $display("    got ok=%0b pa=%h lv=%0d ea=%h %h %h %h",
               got.ok, got.physical_address, got.levels_read,
               got.entry_addr_0, got.entry_addr_1, got.entry_addr_2,
               got.entry_addr_3);
    end
  endfunction

  task automatic send_request(input ptw_req_t req);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.op;
    s_axis_tdata  <= {2'b00, req.is_execute, req.is_write, req.virtual_address,
                      req.table_root, req.word_data, req.word_index};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(request_outcome(req));
    requests_sent++;
  endtask

  task automatic load_word(input logic [11:0] idx, input logic [63:0] data);
    ptw_req_t req;
    req.op = OP_WRITE;
    req.word_index = idx;
    req.word_data = data;
    req.table_root = {$urandom, $urandom};
    req.virtual_address = {$urandom, $urandom};
    req.is_write = 1'($urandom_range(0, 1));
    req.is_execute = 1'($urandom_range(0, 1));
    send_request(req);
  endtask

  // Load any table word the walk would read before it has been written, then translate.
  task automatic translate_va(input logic [63:0] root, input logic [63:0] va,
                              input bit wr, input bit ex);
    ptw_req_t req;
    ptw_result_t res;
    int gw, gl;
    req.op = OP_XLATE;
    req.word_index = 12'($urandom);
    req.word_data = {$urandom, $urandom};
    req.table_root = root;
    req.virtual_address = va;
    req.is_write = wr;
    req.is_execute = ex;
    walk_table(req, res, gw, gl);
    while (gw >= 0) begin
      load_word(12'(gw), make_entry(gl));
      walk_table(req, res, gw, gl);
    end
    send_request(req);
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_memory_size(input logic [15:0] bytes);
    drain_results();
    repeat (16) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bytes;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    readable_bytes = bytes;
    @(posedge clk);
  endtask

  task automatic run_random_walks(input int unsigned count);
    int unsigned stop, step, pick;
    logic [63:0] root, va;
    stop = requests_sent + count;
    step = 0;
    while (requests_sent < stop) begin
      if (step % 48 == 0) begin
        src_gaps = ($urandom_range(0, 3) != 0);
        dst_stalls = ($urandom_range(0, 3) != 0);
      end
      step++;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        load_word(12'($urandom), {$urandom, $urandom});
      end else if (pick == 1) begin
        root = {$urandom, $urandom};
        if ($urandom_range(0, 1))
          root &= CR3_ALLOWED;
        translate_va(root, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end else begin
        root = 64'($urandom_range(0, 7)) << 12;
        root[4:3] = 2'($urandom);
        if ($urandom_range(0, 31) == 0)
          root[$urandom_range(0, 63)] = 1'b1;
        va = {$urandom, $urandom};
        va[63:48] = {16{va[47]}};
        if ($urandom_range(0, 31) == 0)
          va[63:47] = 17'($urandom);
        translate_va(root, va, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    src_gaps = 1'b1;
    dst_stalls = 1'b1;
  endtask

  task automatic test_table_loads;
    load_word(12'd4095, '1);
    load_word(12'd0, 64'h1003);
    load_word(12'd512, 64'h2003);
    load_word(12'd1024, 64'h3003);
    load_word(12'd1536, 64'h4083);
    load_word(12'd1025, 64'h0020_1083);
    load_word(12'd256, 64'h0);
  endtask

  task automatic test_page_sizes;
    translate_va(64'h18, 64'h123, 1'b1, 1'b1);
    translate_va(64'h0, (64'd1 << 21) | 64'h12345, 1'b0, 1'b0);
    load_word(12'd1026, 64'h0020_2083);
    translate_va(64'h0, 64'd2 << 21, 1'b0, 1'b0);
  endtask

  task automatic test_entry_faults;
    load_word(12'd1, 64'h1083);
    translate_va(64'h0, 64'd1 << 39, 1'b0, 1'b0);
    load_word(12'd513, 64'h83);
    translate_va(64'h0, 64'd1 << 30, 1'b0, 1'b0);
    load_word(12'd1537, 64'h0);
    translate_va(64'h0, 64'd1 << 12, 1'b0, 1'b0);
    load_word(12'd1538, 64'h0000_0010_0000_5003);
    translate_va(64'h0, 64'd2 << 12, 1'b0, 1'b0);
    load_word(12'd1539, 64'h5001);
    translate_va(64'h0, 64'd3 << 12, 1'b1, 1'b0);
    load_word(12'd1540, 64'h8000_0000_0000_6003);
    translate_va(64'h0, 64'd4 << 12, 1'b0, 1'b1);
  endtask

  task automatic test_root_checks;
    translate_va(64'h0, 64'd1 << 47, 1'b0, 1'b0);
    translate_va(64'h0, 64'hffff_8000_0000_0000, 1'b0, 1'b0);
    translate_va(64'h1_0000_0000, 64'h123, 1'b0, 1'b0);
    translate_va(64'h8000, 64'h123, 1'b0, 1'b0);
  endtask

  task automatic test_memory_sizes;
    logic [15:0] sizes [7];
    sizes = '{16'd0, 16'd8, 16'h3008, 16'd32767, 16'hffff, 16'd0, 16'd32768};
    sizes[5] = 16'($urandom);
    foreach (sizes[i]) begin
      set_memory_size(sizes[i]);
      run_random_walks(230);
    end
  endtask

  initial begin : result_checker
    ptw_result_t got, want;
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      stall = dst_stalls ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.ok               = m_axis_tdata[0];
      got.physical_address = m_axis_tdata[36:1];
      got.levels_read      = m_axis_tdata[39:37];
      got.entry_addr_0     = m_axis_tdata[54:40];
      got.entry_addr_1     = m_axis_tdata[69:55];
      got.entry_addr_2     = m_axis_tdata[84:70];
      got.entry_addr_3     = m_axis_tdata[99:85];
      if (pending_results.size() == 0) begin
        flag_error("result with no request outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_error("result mismatch", want, got);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_loads();
    test_page_sizes();
    test_entry_faults();
    test_root_checks();
    test_memory_sizes();
    drain_results();
    repeat (24) @(posedge clk);
    if (mismatches == 0)
      $display("x86_page_table_walker_tb: clean");
    else
      $display("x86_page_table_walker_tb: errors");
    $finish;
  end

endmodule
